>>> hdl/xcpd_pkg.sv
// ---------------------------------------------------------------------------
// xcpd_pkg
// Types and constants shared by the packet deframer modules.
// ---------------------------------------------------------------------------
package xcpd_pkg;

  // Input operation carried on in_tuser
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kind carried on out_tuser
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Packet status codes
  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_CSUM    = 2'd1;
  localparam logic [1:0] ST_LENGTH  = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  // Configuration register map
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd2;

  localparam logic [7:0]  START_BYTE_RST = 8'd170;
  localparam logic [5:0]  MAX_LENGTH_RST = 6'd32;
  localparam logic [15:0] TIMEOUT_RST    = 16'd100;

  localparam int OUT_TDATA_W = 32;

  // Controller -> datapath commands
  typedef struct packed {
    logic       start_pkt;  // start byte seen: load checksum, clear held fields
    logic       take_cmd;
    logic       take_len;
    logic       take_data;
    logic       tick;       // count one idle tick
    logic       clr_idle;
    logic       set_stat;   // latch stat_code for the closing result
    logic [1:0] stat_code;
    logic       emit_start; // rewind payload read pointer
    logic       emit_run;   // stream stored payload to the output
    logic       load_stat;  // put the status word in the output register
  } xcpd_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic is_start;    // rx byte equals start byte
    logic len_bad;     // rx byte above the length limit
    logic len_zero;
    logic data_last;   // this payload byte completes the run
    logic sum_ok;      // rx byte matches running checksum
    logic tick_expire; // a tick now reaches the timeout
    logic emit_done;   // every payload byte handed to the output
    logic out_free;    // output register can load this cycle
  } xcpd_sts_t;

endpackage

>>> hdl/xcpd_ctrl.sv
// ---------------------------------------------------------------------------
// xcpd_ctrl
// Framing state machine: tracks packet phase, accepts input words and
// sequences the result run.
// ---------------------------------------------------------------------------
module xcpd_ctrl import xcpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  logic      in_op,
  input  xcpd_sts_t sts,
  output xcpd_cmd_t cmd
);

  // packet phase
  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_CMD   = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_CHECK = 3'd4;

  // result sequencing
  localparam logic [1:0] S_RUN  = 2'd0;
  localparam logic [1:0] S_EMIT = 2'd1;
  localparam logic [1:0] S_STAT = 2'd2;

  logic [2:0] phase_r, phase_nxt;
  logic [1:0] state_r, state_nxt;
  logic       in_fire;

  assign in_tready = (state_r == S_RUN);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    phase_nxt = phase_r;
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_RUN: begin
        if (in_fire) begin
          if (in_op == OP_TICK) begin
            if (phase_r != PH_HUNT) begin
              cmd.tick = 1'b1;
              if (sts.tick_expire) begin
                cmd.clr_idle  = 1'b1;
                cmd.set_stat  = 1'b1;
                cmd.stat_code = ST_TIMEOUT;
                phase_nxt     = PH_HUNT;
                state_nxt     = S_STAT;
              end
            end
          end else begin
            unique case (phase_r)
              PH_HUNT: begin
                if (sts.is_start) begin
                  cmd.start_pkt = 1'b1;
                  cmd.clr_idle  = 1'b1;
                  phase_nxt     = PH_CMD;
                end
              end
              PH_CMD: begin
                cmd.take_cmd = 1'b1;
                cmd.clr_idle = 1'b1;
                phase_nxt    = PH_LEN;
              end
              PH_LEN: begin
                cmd.take_len = 1'b1;
                cmd.clr_idle = 1'b1;
                if (sts.len_bad) begin
                  cmd.set_stat  = 1'b1;
                  cmd.stat_code = ST_LENGTH;
                  phase_nxt     = PH_HUNT;
                  state_nxt     = S_STAT;
                end else if (sts.len_zero) begin
                  phase_nxt = PH_CHECK;
                end else begin
                  phase_nxt = PH_DATA;
                end
              end
              PH_DATA: begin
                cmd.take_data = 1'b1;
                cmd.clr_idle  = 1'b1;
                if (sts.data_last) begin
                  phase_nxt = PH_CHECK;
                end
              end
              PH_CHECK: begin
                cmd.clr_idle = 1'b1;
                cmd.set_stat = 1'b1;
                phase_nxt    = PH_HUNT;
                if (sts.sum_ok) begin
                  cmd.stat_code  = ST_GOOD;
                  cmd.emit_start = 1'b1;
                  state_nxt      = S_EMIT;
                end else begin
                  cmd.stat_code = ST_CSUM;
                  state_nxt     = S_STAT;
                end
              end
              default: begin
                phase_nxt = PH_HUNT;
              end
            endcase
          end
        end
      end
      S_EMIT: begin
        cmd.emit_run = 1'b1;
        if (sts.emit_done && sts.out_free) begin
          cmd.load_stat = 1'b1;
          state_nxt     = S_RUN;
        end
      end
      S_STAT: begin
        if (sts.out_free) begin
          cmd.load_stat = 1'b1;
          state_nxt     = S_RUN;
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      state_r <= S_RUN;
    end else begin
      phase_r <= phase_nxt;
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/xcpd_dp.sv
// ---------------------------------------------------------------------------
// xcpd_dp
// Deframer datapath: config registers, header capture, checksum, idle
// counter, payload memory and the output register.
// ---------------------------------------------------------------------------
module xcpd_dp import xcpd_pkg::*; #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [7:0]             rx_byte,
  input  xcpd_cmd_t              cmd,
  output xcpd_sts_t              sts,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [7:0] LIMIT_HI = 8'(MAX_PAYLOAD);

  // configuration
  logic [7:0]  start_byte_r;
  logic [5:0]  max_len_r;
  logic [15:0] timeout_r;

  // packet state
  logic [7:0]    cmd_r;
  logic [7:0]    len_r;
  logic [CW-1:0] idx_r;
  logic [7:0]    xor_r;
  logic [15:0]   idle_r;
  logic [1:0]    stat_r;

  // payload memory and read stage
  logic [7:0]    mem [MAX_PAYLOAD];
  logic [7:0]    mem_q;
  logic [CW-1:0] rd_idx_r;
  logic          rdv_r;

  // output register
  logic       out_valid_r;
  logic       out_kind_r;
  logic [7:0] out_pb_r;
  logic [7:0] out_cmd_r;
  logic [7:0] out_len_r;
  logic [1:0] out_st_r;
  logic       out_last_r;

  logic [7:0]  limit;
  logic [15:0] idle_inc;
  logic        remaining;
  logic        issue;
  logic        move;
  logic        out_free;

  assign limit    = ({2'b00, max_len_r} < LIMIT_HI) ? {2'b00, max_len_r} : LIMIT_HI;
  assign idle_inc = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;

  assign out_free  = !out_valid_r || out_tready;
  assign move      = rdv_r && out_free;
  assign remaining = 8'(rd_idx_r) < len_r;
  assign issue     = cmd.emit_run && remaining && (!rdv_r || move);

  always_comb begin
    sts.is_start    = (rx_byte == start_byte_r);
    sts.len_bad     = (rx_byte > limit);
    sts.len_zero    = (rx_byte == 8'd0);
    sts.data_last   = ((8'(idx_r) + 8'd1) >= len_r);
    sts.sum_ok      = (rx_byte == xor_r);
    sts.tick_expire = (idle_inc >= timeout_r);
    sts.emit_done   = !remaining && !rdv_r;
    sts.out_free    = out_free;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
      max_len_r    <= MAX_LENGTH_RST;
      timeout_r    <= TIMEOUT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START_BYTE: start_byte_r <= cfg_data[7:0];
        REG_MAX_LENGTH: max_len_r    <= cfg_data[5:0];
        REG_TIMEOUT:    timeout_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // idle tick counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r <= '0;
    end else if (cmd.clr_idle) begin
      idle_r <= '0;
    end else if (cmd.tick) begin
      idle_r <= idle_inc;
    end
  end

  // header, checksum, payload index
  always_ff @(posedge clk) begin
    if (cmd.start_pkt) begin
      xor_r <= rx_byte;
      cmd_r <= '0;
      len_r <= '0;
      idx_r <= '0;
    end
    if (cmd.take_cmd) begin
      cmd_r <= rx_byte;
      xor_r <= xor_r ^ rx_byte;
    end
    if (cmd.take_len) begin
      len_r <= rx_byte;
      xor_r <= xor_r ^ rx_byte;
      idx_r <= '0;
    end
    if (cmd.take_data) begin
      xor_r <= xor_r ^ rx_byte;
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.set_stat) begin
      stat_r <= cmd.stat_code;
    end
  end

  // payload memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.take_data) begin
      mem[idx_r[AW-1:0]] <= rx_byte;
    end
    if (issue) begin
      mem_q <= mem[rd_idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdv_r <= 1'b0;
    end else if (cmd.emit_start) begin
      rdv_r <= 1'b0;
    end else if (issue) begin
      rdv_r <= 1'b1;
    end else if (move) begin
      rdv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      rd_idx_r <= '0;
    end else if (issue) begin
      rd_idx_r <= rd_idx_r + CW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move || cmd.load_stat) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_kind_r <= KIND_PAYLOAD;
      out_pb_r   <= mem_q;
      out_cmd_r  <= cmd_r;
      out_len_r  <= len_r;
      out_st_r   <= ST_GOOD;
      out_last_r <= 1'b0;
    end else if (cmd.load_stat) begin
      out_kind_r <= KIND_STATUS;
      out_pb_r   <= '0;
      out_cmd_r  <= cmd_r;
      out_len_r  <= len_r;
      out_st_r   <= stat_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'd0, out_st_r, out_len_r, out_cmd_r, out_pb_r};

endmodule

>>> hdl/xor_checked_packet_deframer_top.sv
// Start-byte framed packet deframer with XOR checksum. Each input word is a
// received byte (in_tuser = 0) or one timer tick (in_tuser = 1). Bytes are
// dropped until the start byte; then come command, length, payload and a
// checksum that must equal the XOR of start, command, length and payload.
// A good packet produces its payload bytes (out_tuser = 0) followed by a
// status word (out_tuser = 1, out_tlast = 1); a bad length, bad checksum or
// inter-byte timeout produces the status word alone. While a packet is being
// received one input word is taken every cycle. After the checksum byte of a
// good packet with a nonzero length, input is held off while the first
// byte is read from the single registered read port of the payload memory,
// while the payload streams out one byte per cycle, and while the status
// word is loaded. With a zero length only the status load remains, and an
// error status holds input off only while its status word is loaded. Output
// stalls stretch these runs. A finished result waiting in the output register
// does not block the next input word. The payload memory needs no clearing
// after reset: only bytes written in the current packet are ever read.
// ---------------------------------------------------------------------------
// xor_checked_packet_deframer_top
// Top level: stream ports, config port, controller and datapath.
// ---------------------------------------------------------------------------
module xor_checked_packet_deframer_top import xcpd_pkg::*; #(
  parameter int MAX_PAYLOAD = 32  // payload memory depth, 1 to 63
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] rx_byte
  input  logic                   in_tuser,   // [0] operation
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] payload_byte, [15:8] command,
                                             // [23:16] length, [25:24] status
  output logic                   out_tuser,  // [0] kind
  output logic                   out_tlast,  // last
  // config write port
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,  // 0 start byte, 1 max length, 2 timeout
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  xcpd_cmd_t cmd;
  xcpd_sts_t sts;

  // config writes are always accepted
  assign cfg_ready = 1'b1;

  xcpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  xcpd_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rx_byte    (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  // status word never overwrites a result still waiting downstream
  a_stat_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_stat |-> sts.out_free)
    else $error("status loaded into a busy output register");

  // input is held off while a good packet streams out
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_start |=> !in_tready)
    else $error("input accepted during payload streaming");

  // an expiring tick always closes the packet with a status
  a_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tick && sts.tick_expire) |-> (cmd.set_stat && cmd.stat_code == ST_TIMEOUT))
    else $error("timeout not reported");
`endif

endmodule

>>> dv/xor_checked_packet_deframer_top_tb.sv
// ---------------------------------------------------------------------------
// xor_checked_packet_deframer_top_tb
// Self-checking bench for the framed packet deframer. A queue of pending
// words (bytes and ticks) feeds a clocked driver. A clocked monitor runs a
// behavioral deframer on every accepted word and compares each result word
// against the oldest predicted one. Both stream sides idle at random unless steady is set.
// ---------------------------------------------------------------------------
module xor_checked_packet_deframer_top_tb;
  import xcpd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PAYLOAD   = 32;
  localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int SETTLE_CYCLES = 64;    // longer than an unstalled run of payload streaming

  // Index 3 is not mapped; a write there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } rx_word_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload;
    logic [7:0] command;
    logic [7:0] length;
    logic [1:0] status;
    logic       last;
  } result_t;

  typedef enum logic [2:0] {
    RX_HUNT, RX_CMD, RX_LEN, RX_DATA, RX_CHECK
  } rx_phase_t;

  // Shapes of generated traffic
  typedef enum int {
    SHAPE_GOOD, SHAPE_BAD_SUM, SHAPE_LONG, SHAPE_STALL, SHAPE_NOISE
  } pkt_shape_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  xor_checked_packet_deframer_top #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Bench bookkeeping
  // -------------------------------------------------------------------------
  rx_word_t pending_words[$];
  result_t  expected_results[$];
  int       words_queued = 0;
  int       errors = 0;
  int       quiet_cycles = 0;
  bit       word_taken = 1'b0;  // input word accepted at the last rising edge
  bit       steady = 1'b0;      // no idling on either side while set

  // Shadow of the register file, updated on each config handshake
  logic [7:0]  shadow_start   = START_BYTE_RST;
  logic [5:0]  shadow_maxlen  = MAX_LENGTH_RST;
  logic [15:0] shadow_timeout = TIMEOUT_RST;

  // Behavioral deframer state
  rx_phase_t   rx_phase = RX_HUNT;
  logic [7:0]  held_cmd = '0;
  logic [7:0]  held_len = '0;
  logic [5:0]  byte_idx = '0;
  logic [7:0]  run_xor = '0;
  logic [15:0] idle_ticks = '0;
  logic [7:0]  payload_copy[MAX_PAYLOAD];

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_START_BYTE: shadow_start = val[7:0];
      REG_MAX_LENGTH: shadow_maxlen = val[5:0];
      REG_TIMEOUT:    shadow_timeout = val;
      default: ;  // unmapped index: no effect
    endcase
  endtask

  function automatic result_t make_result(input logic kind, input logic [7:0] pb,
                                          input logic [1:0] st, input logic last);
    result_t r;
    r.kind    = kind;
    r.payload = pb;
    r.command = held_cmd;
    r.length  = held_len;
    r.status  = st;
    r.last    = last;
    return r;
  endfunction

  // Closing status word; always returns to hunting
  task automatic close_packet(input logic [1:0] st);
    expected_results.push_back(make_result(KIND_STATUS, 8'h00, st, 1'b1));
    rx_phase   = RX_HUNT;
    idle_ticks = '0;
  endtask

  // Predict the result words caused by one accepted input word
  task automatic deframe_word(input logic op, input logic [7:0] b);
    logic [5:0] limit;
    limit = (shadow_maxlen < MAX_PAYLOAD) ? shadow_maxlen : 6'(MAX_PAYLOAD);
    if (op == OP_TICK) begin
      // ticks only count inside a packet; counter saturates
      if (rx_phase != RX_HUNT) begin
        if (idle_ticks != 16'hFFFF) idle_ticks++;
        if (idle_ticks >= shadow_timeout) close_packet(ST_TIMEOUT);
      end
    end else if (rx_phase == RX_HUNT) begin
      if (b == shadow_start) begin
        run_xor    = b;
        held_cmd   = '0;
        held_len   = '0;
        byte_idx   = '0;
        idle_ticks = '0;
        rx_phase   = RX_CMD;
      end
    end else begin
      idle_ticks = '0;
      case (rx_phase)
        RX_CMD: begin
          held_cmd = b;
          run_xor ^= b;
          rx_phase = RX_LEN;
        end
        RX_LEN: begin
          held_len = b;
          run_xor ^= b;
          if (b > limit) begin
            close_packet(ST_LENGTH);
          end else begin
            byte_idx = '0;
            rx_phase = (b == 8'd0) ? RX_CHECK : RX_DATA;
          end
        end
        RX_DATA: begin
          if (byte_idx < MAX_PAYLOAD) payload_copy[byte_idx] = b;
          run_xor ^= b;
          byte_idx++;
          if (byte_idx >= held_len) rx_phase = RX_CHECK;
        end
        default: begin
          if (b != run_xor) begin
            close_packet(ST_CSUM);
          end else begin
            for (int k = 0; k < held_len && k < MAX_PAYLOAD; k++)
              expected_results.push_back(make_result(KIND_PAYLOAD, payload_copy[k],
                                                     ST_GOOD, 1'b0));
            close_packet(ST_GOOD);
          end
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // -------------------------------------------------------------------------
  // Monitor: handshakes sampled at the rising edge, plus the watchdog
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    bit      moved;
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (in_tvalid && in_tready) begin
        deframe_word(in_tuser, in_tdata);
        word_taken = 1'b1;
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        moved = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          $error("result word 0x%0h arrived with nothing expected", out_tdata);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, out_tuser);
          check_field("payload_byte", want.payload, out_tdata[7:0]);
          check_field("command", want.command, out_tdata[15:8]);
          check_field("length", want.length, out_tdata[23:16]);
          check_field("status", want.status, out_tdata[25:24]);
          check_field("last", want.last, out_tlast);
          check_field("tdata pad", 0, out_tdata[OUT_TDATA_W-1:26]);
        end
      end
      if (moved) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Driver: new input word and sink ready at the falling edge
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    rx_word_t w;
    if (rst_n && (!in_tvalid || word_taken)) begin
      word_taken = 1'b0;
      if (pending_words.size() > 0 && (steady || $urandom_range(99) >= 21)) begin
        w = pending_words.pop_front();
        in_tdata  <= w.data;
        in_tuser  <= w.op;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= rst_n && (steady || $urandom_range(99) >= 21);
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic push_word(input logic op, input logic [7:0] data);
    rx_word_t w;
    w.op   = op;
    w.data = data;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic push_ticks(input int n);
    for (int i = 0; i < n; i++) push_word(OP_TICK, 8'($urandom));
  endtask

  // Config writes happen only with the deframer idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every word sent and every result back, then let the block settle
  task automatic drain();
    while (pending_words.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One packet at the current settings; force_len < 0 picks a length
  task automatic queue_packet(input pkt_shape_t shape, input int force_len);
    logic [7:0] frame[$];
    logic [7:0] sum;
    logic [7:0] nb;
    int limit, len, cut, gap_max;
    if (shape == SHAPE_NOISE) begin
      // noise never opens a packet, so every shape ends on its own
      repeat ($urandom_range(4, 1)) begin
        nb = 8'($urandom);
        if (nb == shadow_start) nb = ~nb;
        push_word(OP_BYTE, nb);
      end
      return;
    end
    limit = (shadow_maxlen < MAX_PAYLOAD) ? shadow_maxlen : MAX_PAYLOAD;
    if (force_len >= 0) len = force_len;
    else if (shape == SHAPE_LONG) len = $urandom_range(255, limit + 1);
    else if ($urandom_range(9) == 0) len = limit;
    else len = $urandom_range((limit < 8) ? limit : 8, 0);
    frame.push_back(shadow_start);
    frame.push_back(8'($urandom));
    frame.push_back(8'(len));
    if (shape != SHAPE_LONG) begin
      for (int i = 0; i < len; i++) frame.push_back(8'($urandom));
      sum = '0;
      foreach (frame[i]) sum ^= frame[i];
      if (shape == SHAPE_BAD_SUM) sum ^= 8'(1 << $urandom_range(7));
      frame.push_back(sum);
    end
    cut = (shape == SHAPE_STALL) ? $urandom_range(frame.size() - 1, 1) : frame.size();
    // gaps inside a packet stay below the timeout, the boundary included
    gap_max = (shadow_timeout > 1) ? ((shadow_timeout - 1 < 6) ? shadow_timeout - 1 : 6) : 0;
    for (int i = 0; i < cut; i++) begin
      if (i == 0 && $urandom_range(4) == 0) push_ticks($urandom_range(2, 1));
      else if (i > 0 && gap_max > 0 && $urandom_range(3) == 0)
        push_ticks($urandom_range(gap_max, 1));
      push_word(OP_BYTE, frame[i]);
    end
    if (shape == SHAPE_STALL) push_ticks((shadow_timeout == 0) ? 1 : shadow_timeout);
  endtask

  // Mixed traffic, every packet closing itself, then drain
  task automatic random_traffic(input int n);
    int first, pick;
    first = words_queued;
    while (words_queued - first < n) begin
      pick = $urandom_range(99);
      if (pick < 60) queue_packet(SHAPE_GOOD, -1);
      else if (pick < 72) queue_packet(SHAPE_BAD_SUM, -1);
      else if (pick < 82) queue_packet(SHAPE_LONG, -1);
      // a stall costs a full timeout of ticks; only short timeouts get one
      else if (pick < 92)
        queue_packet((shadow_timeout <= 20) ? SHAPE_STALL : SHAPE_BAD_SUM, -1);
      else queue_packet(SHAPE_NOISE, -1);
    end
    drain();
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Upper bits of the written words must be masked off
    write_reg(REG_START_BYTE, 16'h5AAA);
    write_reg(REG_MAX_LENGTH, 16'hFFE0);
    write_reg(REG_TIMEOUT, 16'd2);
    write_reg(REG_UNUSED, 16'h1234);

    // Directed: ticks while hunting are dropped
    push_ticks(2);
    // zero length, a tick between length and checksum
    push_word(OP_BYTE, 8'hAA);
    push_word(OP_BYTE, 8'hFF);
    push_word(OP_BYTE, 8'h00);
    push_ticks(1);
    push_word(OP_BYTE, 8'h55);
    // checksum mismatch
    push_word(OP_BYTE, 8'hAA);
    push_word(OP_BYTE, 8'h00);
    push_word(OP_BYTE, 8'h01);
    push_word(OP_BYTE, 8'h55);
    push_word(OP_BYTE, 8'h01);
    // length far above the limit
    push_word(OP_BYTE, 8'hAA);
    push_word(OP_BYTE, 8'h12);
    push_word(OP_BYTE, 8'hFF);
    // timeout before the command, then before the length
    push_word(OP_BYTE, 8'hAA);
    push_ticks(2);
    push_word(OP_BYTE, 8'hAA);
    push_word(OP_BYTE, 8'h34);
    push_ticks(2);
    drain();

    // Start byte zero, full payload limit
    write_reg(REG_START_BYTE, 16'h0000);
    write_reg(REG_MAX_LENGTH, 16'd32);
    write_reg(REG_TIMEOUT, 16'd5);
    queue_packet(SHAPE_GOOD, 32);
    random_traffic(16);

    // Start byte all ones, only empty packets pass, first tick aborts
    write_reg(REG_START_BYTE, 16'h00FF);
    write_reg(REG_MAX_LENGTH, 16'd0);
    write_reg(REG_TIMEOUT, 16'd0);
    random_traffic(16);

    // Limit register above the memory depth; no idling on either side
    write_reg(REG_START_BYTE, 16'($urandom));
    write_reg(REG_MAX_LENGTH, 16'd63);
    write_reg(REG_TIMEOUT, 16'd1);
    steady = 1'b1;
    queue_packet(SHAPE_LONG, 33);
    queue_packet(SHAPE_GOOD, 32);
    random_traffic(16);
    steady = 1'b0;

    // Arbitrary mid-range settings
    write_reg(REG_START_BYTE, 16'($urandom));
    write_reg(REG_MAX_LENGTH, 16'($urandom_range(31, 1)));
    write_reg(REG_TIMEOUT, 16'($urandom_range(20, 2)));
    random_traffic(16);

    // Back to the reset values
    write_reg(REG_START_BYTE, 16'(START_BYTE_RST));
    write_reg(REG_MAX_LENGTH, 16'(MAX_LENGTH_RST));
    write_reg(REG_TIMEOUT, TIMEOUT_RST);
    random_traffic(16);

    // Largest timeout: gaps inside a packet never abort it
    write_reg(REG_TIMEOUT, 16'hFFFF);
    queue_packet(SHAPE_GOOD, 3);
    queue_packet(SHAPE_BAD_SUM, 2);
    drain();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
